FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker of the core.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSVS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSVS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: rtl/core/tsvs_pkg.sv
// Package for the supported versions selector: status codes, phase type,
// register indexes, version constants and the structs between modules. No dependencies.
`timescale 1ns / 1ps

package tsvs_pkg;

	localparam int unsigned VER_W = 6;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 6;
	localparam int unsigned LEN_W = 8;
	localparam int unsigned SEEN_W = 9;

	localparam logic [7:0] MAJOR_TLS = 8'd3;
	localparam logic [7:0] MINOR_MAX = 8'd4;
	localparam int unsigned VER_SCALE = 10;
	localparam logic [VER_W-1:0] VER_BASE = VER_W'(3 * VER_SCALE);
	localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

	localparam logic [VER_W-1:0] RST_SERVER_HIGHEST = 6'd34;
	localparam logic [VER_W-1:0] RST_SERVER_LOWEST = 6'd31;
	localparam logic RST_TLS13_MODE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SERVER_HIGHEST = 2'd0,
		REG_SERVER_LOWEST  = 2'd1,
		REG_TLS13_MODE     = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD         = 3'd1,
		ST_UNKNOWN     = 3'd2,
		ST_UNSUPPORTED = 3'd3,
		ST_SKIPPED     = 3'd4
	} status_t;

	typedef enum logic {
		PH_LENGTH = 1'b0,
		PH_BODY   = 1'b1
	} phase_t;

	typedef struct packed {
		logic [VER_W-1:0] server_highest;
		logic [VER_W-1:0] server_lowest;
		logic             tls13_mode;
	} cfg_t;

	typedef struct packed {
		status_t          status;
		logic [VER_W-1:0] offered_version;
		logic [VER_W-1:0] chosen_version;
	} res_t;

endpackage

FILE: rtl/core/tls_supported_versions_selector_core.sv
// Top level of the TLS 1.3 supported versions selector core.
// Depends on tsvs_pkg and tsvs_tracker.
`timescale 1ns / 1ps

// The core takes the body of a client supported versions extension one byte
// per word, the length byte first and the final byte flagged by last, and
// returns one result word for each final byte: a status, the highest
// recognized client version and the highest version inside the configured
// server range, both encoded as major*10+minor. The core takes one byte
// per cycle while no final byte waits in the input register. A byte is
// captured in an input register and evaluated there against the running
// extension state; for a final byte the result is loaded into the output
// register at the end of the cycle in which that byte is evaluated, and the
// result word is offered from the output register. The output register
// frees the input side: bytes that carry no result keep flowing while a
// result waits, and only a final byte held in the input register waits for
// the output register to drain.
// Configuration registers are written through a separate valid/ready port
// that is always ready; they are expected to change only while no extension
// is in flight. Writes to an index past the register list are dropped.

module tls_supported_versions_selector_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// Byte stream in.
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         ext_byte,
	input  logic                               last,
	// Result out.
	output logic                               out_valid,
	input  logic                               out_stall,
	output tsvs_pkg::status_t                  status,
	output logic [tsvs_pkg::VER_W-1:0]         offered_version,
	output logic [tsvs_pkg::VER_W-1:0]         chosen_version,
	// Configuration writes.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tsvs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tsvs_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tsvs_pkg::*;

	cfg_t        cfg_q;
	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        adv_s1;
	logic        take_in;
	logic        out_vld_q;
	res_t        out_q;
	res_t        res;

	// Configuration registers. The port never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.server_highest <= RST_SERVER_HIGHEST;
			cfg_q.server_lowest <= RST_SERVER_LOWEST;
			cfg_q.tls13_mode <= RST_TLS13_MODE;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_SERVER_HIGHEST: cfg_q.server_highest <= cfg_data;
				REG_SERVER_LOWEST:  cfg_q.server_lowest <= cfg_data;
				REG_TLS13_MODE:     cfg_q.tls13_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// The byte in the input register is evaluated this cycle unless it is a
	// final byte and the output register is still held by the consumer.
	assign adv_s1 = vld_s1 && (!last_s1 || !out_vld_q || !out_stall);
	assign take_in = in_valid && !in_stall;
	assign in_stall = vld_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!vld_s1 || adv_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= ext_byte;
			last_s1 <= last;
		end
	end

	tsvs_tracker u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.proc     (adv_s1),
		.ext_byte (byte_s1),
		.last     (last_s1),
		.cfg      (cfg_q),
		.res      (res)
	);

	// Output register: loaded by an evaluated final byte, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign status = out_q.status;
	assign offered_version = out_q.offered_version;
	assign chosen_version = out_q.chosen_version;

endmodule

FILE: rtl/core/tsvs_tracker.sv
// Per-extension state of the selector: phase, length check, pair tracking
// and the verdict for the final byte. Depends on tsvs_pkg.
`timescale 1ns / 1ps

module tsvs_tracker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            proc,
	input  logic [7:0]      ext_byte,
	input  logic            last,
	input  tsvs_pkg::cfg_t  cfg,
	output tsvs_pkg::res_t  res
);
	import tsvs_pkg::*;

	phase_t             phase_q, phase_d;
	logic [LEN_W-1:0]   decl_q, decl_d;
	logic [SEEN_W-1:0]  seen_q, seen_d;
	logic               maj3_q, maj3_d;
	logic [VER_W-1:0]   client_q, client_d;
	logic [VER_W-1:0]   chosen_q, chosen_d;
	logic [VER_W-1:0]   ver;
	logic               recog;
	logic               in_range;

	assign recog = maj3_q && (ext_byte <= MINOR_MAX);
	assign ver = VER_BASE + {3'b000, ext_byte[2:0]};
	assign in_range = (ver <= cfg.server_highest) && (ver >= cfg.server_lowest);

	always_comb begin
		phase_d = phase_q;
		decl_d = decl_q;
		seen_d = seen_q;
		maj3_d = maj3_q;
		client_d = client_q;
		chosen_d = chosen_q;
		case (phase_q)
			PH_LENGTH: begin
				decl_d = ext_byte;
				seen_d = '0;
				maj3_d = 1'b0;
				client_d = '0;
				chosen_d = '0;
				phase_d = PH_BODY;
			end
			PH_BODY: begin
				seen_d = (seen_q == SEEN_MAX) ? seen_q : seen_q + 1'b1;
				if (seen_d[0]) begin
					maj3_d = (ext_byte == MAJOR_TLS);
				end else if (recog) begin
					if (ver > client_q) begin
						client_d = ver;
					end
					if (in_range && (ver > chosen_q)) begin
						chosen_d = ver;
					end
				end
			end
			default: begin
				phase_d = PH_LENGTH;
			end
		endcase
		if (last) begin
			phase_d = PH_LENGTH;
		end
	end

	// The verdict looks at the state as it stands after this byte.
	always_comb begin
		res.offered_version = '0;
		res.chosen_version = '0;
		if (!cfg.tls13_mode) begin
			res.status = ST_SKIPPED;
		end else if ((seen_d != {1'b0, decl_d}) || decl_d[0]) begin
			res.status = ST_BAD;
		end else if (client_d == '0) begin
			res.status = ST_UNKNOWN;
		end else if (chosen_d == '0) begin
			res.status = ST_UNSUPPORTED;
			res.offered_version = client_d;
		end else begin
			res.status = ST_OK;
			res.offered_version = client_d;
			res.chosen_version = chosen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LENGTH;
			decl_q <= '0;
			seen_q <= '0;
			maj3_q <= 1'b0;
			client_q <= '0;
			chosen_q <= '0;
		end else if (proc) begin
			phase_q <= phase_d;
			decl_q <= decl_d;
			seen_q <= seen_d;
			maj3_q <= maj3_d;
			client_q <= client_d;
			chosen_q <= chosen_d;
		end
	end

endmodule

FILE: rtl/core/tsvs_checker.sv
// Port-level checker for the selector core and the bind that attaches it.
// Depends on tsvs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsvs_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  tsvs_pkg::status_t                  status,
	input  logic [tsvs_pkg::VER_W-1:0]         offered_version,
	input  logic [tsvs_pkg::VER_W-1:0]         chosen_version
);
	import tsvs_pkg::*;

	logic                     held;
	logic                     ok_word;
	logic                     unsup_word;
	logic                     err_word;
	logic                     ok_vers;
	logic                     unsup_vers;
	logic                     clear_vers;
	logic [3+2*VER_W-1:0]     out_word;

	assign held = out_valid && out_stall;
	assign out_word = {status, offered_version, chosen_version};
	assign ok_word = out_valid && (status == ST_OK);
	assign unsup_word = out_valid && (status == ST_UNSUPPORTED);
	assign err_word = out_valid &&
		((status == ST_BAD) || (status == ST_UNKNOWN) || (status == ST_SKIPPED));
	assign ok_vers = (chosen_version != '0) && (chosen_version <= offered_version);
	assign unsup_vers = (offered_version != '0) && (chosen_version == '0);
	assign clear_vers = (offered_version == '0) && (chosen_version == '0);

	// A held result keeps its word.
	`TSVS_ASSERT_NXT(a_out_hold, clk, arst_n, held, out_valid && $stable(out_word))

	// A success names a chosen version no higher than the client's best.
	`TSVS_ASSERT_IMP(a_ok_versions, clk, arst_n, ok_word, ok_vers)

	// Unsupported keeps the client version but chooses nothing.
	`TSVS_ASSERT_IMP(a_unsup_versions, clk, arst_n, unsup_word, unsup_vers)

	// Every other error clears both versions.
	`TSVS_ASSERT_IMP(a_err_versions, clk, arst_n, err_word, clear_vers)

endmodule

bind tls_supported_versions_selector_core tsvs_checker u_tsvs_checker (.*);
